[sv/ip_prefix_rule_filter_macros.svh]
// Assertion helpers for the filter RTL, included by ipf_datapath.
`ifndef IP_PREFIX_RULE_FILTER_MACROS_SVH
`define IP_PREFIX_RULE_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IPF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ipf_pkg.sv]
`timescale 1ns / 1ps

package ipf_pkg;

  localparam int MAX_RULES = 64;
  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 6;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ADDR_W);

  typedef logic [2:0] verdict_t;

  localparam verdict_t VERDICT_NONE   = 3'd0;
  localparam verdict_t VERDICT_ALLOW  = 3'd1;
  localparam verdict_t VERDICT_DENY   = 3'd2;
  localparam verdict_t VERDICT_STORED = 3'd3;
  localparam verdict_t VERDICT_FULL   = 3'd4;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  length;
    logic              permit;
  } rule_t;

  typedef struct packed {
    logic     load;   // latch the request
    logic     scan;   // step through the rule table
    logic     store;  // append the latched rule
    logic     emit;   // load the result register
    verdict_t code;
  } ipf_cmd_t;

  typedef struct packed {
    logic lookup;
    logic full;
    logic hit;
    logic permit;
    logic scan_done;
    logic out_free;
  } ipf_sts_t;

  // Leading-ones mask; length 0 gives no bits, 32 gives all.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

[sv/ipf_ctrl.sv]
`timescale 1ns / 1ps

module ipf_ctrl import ipf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  ipf_sts_t sts,
  output ipf_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ADD   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_REPLY = 2'd3;

  logic [1:0] state, state_next;
  verdict_t   reply, reply_next;
  logic       accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);

  always_comb begin
    state_next = state;
    reply_next = reply;
    cmd        = '0;
    cmd.code   = reply;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        // op was latched on the previous edge
        if (sts.lookup) begin
          state_next = S_SCAN;
        end else if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.store  = !sts.full;
          cmd.code   = sts.full ? VERDICT_FULL : VERDICT_STORED;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          reply_next = sts.permit ? VERDICT_ALLOW : VERDICT_DENY;
          state_next = S_REPLY;
        end else if (sts.scan_done) begin
          reply_next = VERDICT_NONE;
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    reply <= reply_next;
  end

endmodule

[sv/ipf_datapath.sv]
`timescale 1ns / 1ps
`include "ip_prefix_rule_filter_macros.svh"

module ipf_datapath import ipf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ipf_cmd_t          cmd,
  output ipf_sts_t          sts,
  input  logic              op,
  input  logic [ADDR_W-1:0] address,
  input  logic [LEN_W-1:0]  prefix_length,
  input  logic              rule_allow,
  output logic              res_valid,
  input  logic              res_stall,
  output verdict_t          verdict
);

  rule_t             rules [MAX_RULES];
  rule_t             rd_rule;
  logic              rd_valid;
  logic              op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LEN_W-1:0]  len_q;
  logic              allow_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  issue_idx;
  logic              issue_more;
  logic              full;
  logic              match;
  logic              res_valid_q;
  verdict_t          verdict_q;

  assign issue_more = (issue_idx < count);
  assign full       = (count == CNT_W'(MAX_RULES));
  assign match      = ((addr_q ^ rd_rule.prefix) & prefix_mask(rd_rule.length)) == '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op;
      addr_q  <= address;
      len_q   <= (prefix_length > LEN_MAX) ? LEN_MAX : prefix_length;
      allow_q <= rule_allow;
    end
  end

  // Rule table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rules[count[IDX_W-1:0]] <= '{prefix: addr_q, length: len_q, permit: allow_q};
    end
    if (cmd.scan && issue_more) begin
      rd_rule <= rules[issue_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      issue_idx <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (cmd.store) begin
        count <= count + 1'b1;
      end
      if (cmd.load) begin
        issue_idx <= '0;
        rd_valid  <= 1'b0;
      end else if (cmd.scan && issue_more) begin
        issue_idx <= issue_idx + 1'b1;
        rd_valid  <= 1'b1;
      end else begin
        rd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall) begin
      res_valid_q <= 1'b0;
    end
    if (cmd.emit) begin
      verdict_q <= cmd.code;
    end
  end

  assign res_valid     = res_valid_q;
  assign verdict       = verdict_q;

  assign sts.lookup    = (op_q == OP_LOOKUP);
  assign sts.full      = full;
  assign sts.hit       = rd_valid && match;
  assign sts.permit    = rd_rule.permit;
  assign sts.scan_done = !issue_more && !rd_valid;
  assign sts.out_free  = !res_valid_q || !res_stall;

  `IPF_ASSERT_NOW(a_no_store_full, clk, rst, cmd.store, !full, "rule stored into a full table")
  `IPF_ASSERT_NOW(a_emit_free, clk, rst, cmd.emit, !res_valid_q || !res_stall, "result overwritten")
  `IPF_ASSERT_NEXT(a_count_step, clk, rst, cmd.store, count == CNT_W'($past(count) + 1'b1), "count did not step")

endmodule

[sv/ip_prefix_rule_filter.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_stall  op, address, prefix_length, rule_allow
// result    out        res_valid/res_stall  verdict
//
// A lookup reads the rule table through its single read port, scanned one rule a cycle,
// and stops at the first rule k (from 0) that hits; with no hit it answers none.
// Reset (rst, synchronous) empties the table; rule memory is not cleared.
// A finished result waits in the output register while the next request is taken;
// the block stalls requests only while one is being worked on.

module ip_prefix_rule_filter import ipf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   op,
  input  logic [ADDR_W-1:0]      address,
  input  logic [LEN_W-1:0]       prefix_length,
  input  logic                   rule_allow,
  output logic                   res_valid,
  input  logic                   res_stall,
  output verdict_t               verdict
);

  ipf_cmd_t cmd;
  ipf_sts_t sts;

  ipf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ipf_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .op            (op),
    .address       (address),
    .prefix_length (prefix_length),
    .rule_allow    (rule_allow),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .verdict       (verdict)
  );

endmodule

[verif/ip_prefix_rule_filter_test.sv]
`timescale 1ns / 1ps

module ip_prefix_rule_filter_test;
  import ipf_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 100;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic              op;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  prefix_length;
  logic              rule_allow;
  logic              res_valid;
  logic              res_stall;
  verdict_t          verdict;

  ip_prefix_rule_filter dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .op            (op),
    .address       (address),
    .prefix_length (prefix_length),
    .rule_allow    (rule_allow),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .verdict       (verdict)
  );

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned verdicts_seen;
  verdict_t    expected_verdicts[$];

  // Own copy of the rule table, in arrival order
  logic [ADDR_W-1:0] acl_prefix [MAX_RULES];
  logic [LEN_W-1:0]  acl_length [MAX_RULES];
  logic              acl_permit [MAX_RULES];
  int unsigned       acl_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] leading_ones(input int unsigned len);
    if (len == 0) return '0;
    return {ADDR_W{1'b1}} << (ADDR_W - len);
  endfunction

  // Updates the table and gives the verdict the block should answer with
  function automatic verdict_t classify_request(input logic req_op,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [LEN_W-1:0] len,
                                                input logic allow);
    int unsigned eff_len;
    if (req_op == OP_ADD) begin
      if (acl_count >= MAX_RULES) return VERDICT_FULL;
      eff_len = (len > ADDR_W) ? ADDR_W : len;
      acl_prefix[acl_count] = addr;
      acl_length[acl_count] = LEN_W'(eff_len);
      acl_permit[acl_count] = allow;
      acl_count++;
      return VERDICT_STORED;
    end
    for (int i = 0; i < acl_count; i++) begin
      if (((addr ^ acl_prefix[i]) & leading_ones(acl_length[i])) == '0)
        return acl_permit[i] ? VERDICT_ALLOW : VERDICT_DENY;
    end
    return VERDICT_NONE;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  task automatic send_request(input logic req_op, input logic [ADDR_W-1:0] addr,
                              input logic [LEN_W-1:0] len, input logic allow);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid     <= 1'b1;
    op            <= req_op;
    address       <= addr;
    prefix_length <= len;
    rule_allow    <= allow;
    do @(posedge clk); while (req_stall !== 1'b0);
    expected_verdicts.insert(expected_verdicts.size(),
                             classify_request(req_op, addr, len, allow));
  endtask

  // Sender holds off until every outstanding request has answered
  task automatic wait_for_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic send_lookup(input logic [ADDR_W-1:0] addr);
    send_request(OP_LOOKUP, addr, LEN_W'($urandom_range(0, 63)), 1'($urandom));
  endtask

  task automatic send_random_rule(input int unsigned min_len);
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 9);
    if (pick == 7) len = $urandom_range(33, 63);
    else if (pick == 8) len = $urandom_range(min_len, 7 > min_len ? 7 : min_len);
    else len = $urandom_range(min_len > 8 ? min_len : 8, 32);
    send_request(OP_ADD, $urandom, LEN_W'(len), 1'($urandom));
  endtask

  // Mostly addresses inside or just outside a stored prefix
  function automatic logic [ADDR_W-1:0] pick_lookup_address();
    int unsigned pick;
    int unsigned idx;
    int unsigned len;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (acl_count != 0 && pick < 65) begin
      idx  = $urandom_range(0, acl_count - 1);
      len  = acl_length[idx];
      mask = leading_ones(len);
      addr = (acl_prefix[idx] & mask) | ($urandom & ~mask);
      if (len != 0 && $urandom_range(0, 3) == 0)
        addr[ADDR_W - 1 - $urandom_range(0, len - 1)] ^= 1'b1;
      return addr;
    end
    if (pick < 88) return $urandom;
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
    endcase
  endfunction

  task automatic test_empty_table();
    set_idling(0, 0);
    send_request(OP_LOOKUP, '0, '0, 1'b0);
    send_request(OP_LOOKUP, '1, 6'h3f, 1'b1);
    send_lookup($urandom);
  endtask

  task automatic test_rule_matching();
    set_idling(0, 0);
    send_request(OP_ADD, 32'h0a000000, 6'd8, 1'b1);
    send_request(OP_ADD, 32'h0a010000, 6'd16, 1'b0);  // shadowed by the /8
    send_request(OP_ADD, 32'hc0a80101, 6'd32, 1'b0);
    send_request(OP_ADD, 32'hffffffff, 6'd32, 1'b1);
    send_request(OP_ADD, 32'h00000000, 6'd32, 1'b0);
    send_request(OP_ADD, 32'hac100000, 6'd45, 1'b1);  // saturates to /32
    send_request(OP_ADD, 32'h80000000, 6'd63, 1'b1);
    send_request(OP_ADD, 32'hc0a80101, 6'd32, 1'b1);  // repeat, never wins
    send_lookup(32'h0a010203);
    send_lookup(32'hc0a80101);
    send_lookup(32'hc0a80100);
    send_lookup(32'hffffffff);
    send_lookup(32'h00000000);
    send_lookup(32'hac100000);
    send_lookup(32'hac100001);
    send_lookup(32'h80000000);
    send_lookup(32'h0b000000);
    send_request(OP_LOOKUP, 32'h0affffff, 6'h3f, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned add_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < add_pct) send_random_rule(2);
      else send_lookup(pick_lookup_address());
    end
  endtask

  task automatic test_table_full();
    set_idling(0, 0);
    while (acl_count < MAX_RULES - 2) send_random_rule(12);
    // broad rules last so they only catch what nothing earlier covers
    send_request(OP_ADD, 32'h80000000, 6'd1, 1'b1);
    send_request(OP_ADD, $urandom, 6'd0, 1'b0);
    send_request(OP_ADD, 32'h12345678, 6'd24, 1'b1);
    send_request(OP_ADD, '0, 6'd0, 1'b1);
    send_request(OP_ADD, '1, 6'h3f, 1'b0);
    for (int i = 0; i < 6; i++) send_lookup(pick_lookup_address());
  endtask

  always @(negedge clk) begin
    res_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0) begin
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with no request outstanding", verdict));
      end else begin
        if (verdict !== expected_verdicts[0])
          report_mismatch($sformatf("result %0d: verdict %0d, expected %0d",
                                    verdicts_seen, verdict, expected_verdicts[0]));
        void'(expected_verdicts.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[ip_prefix_rule_filter] ERROR");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    req_valid          = 1'b0;
    op                 = OP_ADD;
    address            = '0;
    prefix_length      = '0;
    rule_allow         = 1'b0;
    res_stall          = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatch_count     = 0;
    quiet_cycles       = 0;
    verdicts_seen      = 0;
    acl_count          = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_rule_matching();
    wait_for_idle();

    set_idling(0, 0);
    test_random_traffic(100, 10);
    set_idling(75, 0);
    test_random_traffic(100, 10);
    wait_for_idle();
    set_idling(0, 75);
    test_random_traffic(100, 10);
    set_idling(23, 23);
    test_random_traffic(100, 10);
    wait_for_idle();

    test_table_full();
    set_idling(23, 23);
    test_random_traffic(100, 10);

    wait_for_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ip_prefix_rule_filter] OK");
    end else begin
      $display("[ip_prefix_rule_filter] ERROR");
    end
    $finish;
  end

endmodule
